// File: hdl/reclaim_tier_protection_policy_unit_assert.svh
// Assertion macros for the reclaim tier protection policy unit.
// Used at the end of the top level; needs clk and rst_n in scope.
`ifndef RECLAIM_TIER_PROTECTION_POLICY_UNIT_ASSERT_SVH
`define RECLAIM_TIER_PROTECTION_POLICY_UNIT_ASSERT_SVH
// implication checked at every edge outside reset
`define RTP_ASSERT_IMP(label, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// implication with the consequent checked in the next cycle
`define RTP_ASSERT_NEXT(label, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// File: hdl/rtpp_pkg.sv
// Package for the reclaim tier protection policy unit.
// Types and constants shared by the divider and the top level.
package rtpp_pkg;
    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_AGE  = 2'd1;
    localparam logic [1:0] KIND_PROT = 2'd2;
    localparam logic [1:0] KIND_LOOK = 2'd3;

    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_SWAP   = 2'd1;
    localparam logic [1:0] REG_TPS    = 2'd2;

    localparam int DIV_BITS = 40;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_RATIO,
        ST_SIXTH,
        ST_BUDGET,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic [DIV_BITS-1:0] num;
        logic [DIV_BITS-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic [DIV_BITS-1:0] quo;
    } div_rsp_t;
endpackage

// File: hdl/rtpp_div.sv
// Radix-2 restoring divider, one quotient bit a cycle.
// Depends on rtpp_pkg.
module rtpp_div (
    input  logic              clk,
    input  logic              rst_n,
    input  rtpp_pkg::div_req_t req,
    output rtpp_pkg::div_rsp_t rsp
);
    import rtpp_pkg::*;

    localparam int CW = $clog2(DIV_BITS + 1);

    logic [DIV_BITS-1:0] quo_reg, quo_next, den_reg, den_next;
    logic [DIV_BITS:0]   rem_reg, rem_next, trial;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                busy_reg, busy_next, done_reg, done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        trial     = {rem_reg[DIV_BITS-1:0], quo_reg[DIV_BITS-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DIV_BITS);
            quo_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[DIV_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[DIV_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
endmodule

// File: hdl/reclaim_tier_protection_policy_unit.sv
// Reclaim tier protection policy unit, top level.
// Depends on rtpp_pkg, rtpp_div and the assertion macro header.
//
// Use: one input beat (valid/stall) gives exactly one output beat.
// kind 0 tick, 1 age event, 2 protect query, 3 look-around sample.
// Ticks, queries, look-around samples and age events not due or with a zero
// file page count go straight to ST_OUT, which loads the output register.
// An age event that falls due with a nonzero file page count takes a sixth
// of that count by reciprocal multiply, then runs the budget step; its
// states are ST_SIXTH, ST_BUDGET and ST_OUT. With 1024 or more scan samples
// the hot ratio goes first through the bit-serial divider (40 steps) in
// ST_DIV_RATIO, before ST_SIXTH.
// The input is stalled while an item is in work.
// Config writes are to be made only while idle; the block does not enforce it.
// Reset: registers take their reset values, budgets zero, no output valid.
// A stalled output holds its beat in the output register; the next item is
// taken and waits in its last step until that beat leaves.
module reclaim_tier_protection_policy_unit #(
    parameter int COUNTER_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [31:0] refault_count,
    input  logic [31:0] file_pages,
    input  logic [31:0] scan_total,
    input  logic [31:0] scan_hot,
    input  logic        is_file,
    input  logic        referenced,
    input  logic        workingset,
    input  logic        active,
    input  logic [3:0]  priority_req,
    input  logic        swap_ok,
    input  logic [9:0]  pages,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        protect,
    output logic        aged,
    output logic [1:0]  boost_now,
    output logic [31:0] tier1_budget,
    output logic [31:0] tier2_budget
);
    import rtpp_pkg::*;

    localparam int CB = COUNTER_BITS;
    localparam logic [CB-1:0] CMAX = {CB{1'b1}};

    state_t state_reg, state_next;
    logic enable_reg;
    logic [7:0] swp_reg;
    logic [9:0] tps_reg;
    logic [31:0] now_reg, now_next, nat_reg, nat_next, lref_reg, lref_next;
    logic [1:0] bl_reg, bl_next;
    logic [31:0] bu_reg, bu_next, sts_reg, sts_next, shs_reg, shs_next;
    logic [CB-1:0] lt_reg, lt_next, lh_reg, lh_next;
    logic [31:0] b1_reg, b1_next, b2_reg, b2_next;
    logic [31:0] ft_reg, ft_next;
    logic [31:0] six_reg, six_next;
    logic [62:0] six_prod;
    logic ratio_reg, ratio_next;
    logic [6:0] r_reg, r_next;
    logic prot_reg, prot_next, aged_reg, aged_next, ov_reg, ov_next;
    logic out_load;
    logic oprot_reg, oaged_reg;
    logic [1:0] oboost_reg;
    logic [31:0] ob1_reg, ob2_reg;
    div_req_t dreq;
    div_rsp_t drsp;

    rtpp_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    function automatic logic before32(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    function automatic logic [33:0] alo(input logic [33:0] v);
        return (v == '0) ? 34'd1 : v;
    endfunction

    logic [1:0] eb;
    assign eb = before32(now_reg, bu_reg) ? bl_reg : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            enable_reg <= 1'b1;
            swp_reg    <= 8'd60;
            tps_reg    <= 10'd100;
            now_reg    <= '0;
            nat_reg    <= 32'd100;
            lref_reg   <= '0;
            bl_reg     <= '0;
            bu_reg     <= '0;
            sts_reg    <= '0;
            shs_reg    <= '0;
            lt_reg     <= '0;
            lh_reg     <= '0;
            b1_reg     <= '0;
            b2_reg     <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            now_reg   <= now_next;
            nat_reg   <= nat_next;
            lref_reg  <= lref_next;
            bl_reg    <= bl_next;
            bu_reg    <= bu_next;
            sts_reg   <= sts_next;
            shs_reg   <= shs_next;
            lt_reg    <= lt_next;
            lh_reg    <= lh_next;
            b1_reg    <= b1_next;
            b2_reg    <= b2_next;
            ov_reg    <= ov_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ENABLE: enable_reg <= cfg_data[0];
                    REG_SWAP:   swp_reg    <= cfg_data[7:0];
                    REG_TPS:    tps_reg    <= cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ft_reg    <= ft_next;
        six_reg   <= six_next;
        ratio_reg <= ratio_next;
        r_reg     <= r_next;
        prot_reg  <= prot_next;
        aged_reg  <= aged_next;
        if (out_load)
        begin
            oprot_reg  <= prot_reg;
            oaged_reg  <= aged_reg;
            oboost_reg <= eb;
            ob1_reg    <= b1_reg;
            ob2_reg    <= b2_reg;
        end
    end

    logic acc;
    assign in_stall = (state_reg != ST_IDLE);
    assign acc = in_valid && !in_stall;

    // age event pre-decode
    logic [31:0] delta, dt, dh;
    logic [1:0] lvl0, lvl;
    logic [38:0] dh100;
    logic [37:0] dt25, dt35;
    assign delta = refault_count - lref_reg;
    assign dt = scan_total - sts_reg;
    assign dh = scan_hot - shs_reg;
    assign dh100 = {dh, 7'd0} - {2'd0, dh, 5'd0} + {5'd0, dh, 2'd0};
    assign dt25 = {1'b0, dt, 5'd0} - {3'd0, dt, 3'd0} + {6'd0, dt};
    assign dt35 = {1'b0, dt, 5'd0} + {5'd0, dt, 1'b0} + {6'd0, dt};
    always_comb
    begin
        priority if (delta >= 32'd768) lvl0 = 2'd3;
        else if (delta >= 32'd384) lvl0 = 2'd2;
        else if (delta >= 32'd64) lvl0 = 2'd1;
        else lvl0 = 2'd0;
        lvl = lvl0;
        if (dt >= 32'd32)
        begin
            if (dh100 < {1'b0, dt25} && lvl0 > 2'd1) lvl = 2'd1;
            else if (dh100 < {1'b0, dt35} && lvl0 > 2'd2) lvl = 2'd2;
        end
    end

    // protect decision
    logic [7:0] swp;
    logic [3:0] mp1, mp2;
    logic tier2, tier1, pr;
    logic [31:0] bud;
    always_comb
    begin
        swp = swap_ok ? swp_reg : 8'd0;
        mp1 = 4'd7;
        mp2 = 4'd4;
        if (swap_ok && swp >= 8'd80)
        begin
            mp2 = 4'd3;
            mp1 = 4'd6;
        end
        if (eb >= 2'd1 && mp2 > 4'd2) mp2 = mp2 - 4'd1;
        if (eb >= 2'd2 && mp1 > 4'd5) mp1 = mp1 - 4'd1;
        tier2 = workingset;
        tier1 = !workingset && referenced;
        pr = tier2 ? (swp <= 8'd140 && priority_req >= mp2)
                   : (swp <= 8'd100 && priority_req >= mp1);
        if (eb >= 2'd2 && tier2 && swp <= 8'd100 && priority_req >= mp2) pr = 1'b1;
        if (!(enable_reg && is_file && (tier1 || tier2))) pr = 1'b0;
        bud = tier2 ? b2_reg : b1_reg;
    end

    // sixth of the file page count: (ft / 2) / 3 by reciprocal multiply
    assign six_prod = 63'(ft_reg[31:1]) * 63'h0_AAAA_AAAB;

    // budget refresh (uses registered ft, ratio and sixth)
    logic [33:0] ft, g1, g2, c1, c2, t1, t2, s1, s2;
    always_comb
    begin
        ft = {2'd0, ft_reg};
        g1 = alo(ft >> 6);
        g2 = alo(ft >> 5);
        if (eb >= 2'd1) begin g1 = g1 + (ft >> 8); g2 = g2 + (ft >> 7); end
        if (eb >= 2'd2) begin g1 = g1 + (ft >> 9); g2 = g2 + (ft >> 8); end
        if (eb >= 2'd3) begin g1 = g1 + (ft >> 10); g2 = g2 + (ft >> 9); end
        c1 = alo(ft >> 3);
        c2 = alo({2'd0, six_reg});
        if (g1 > c1) g1 = c1;
        if (g2 > c2) g2 = c2;
        s1 = {1'b0, b1_reg, 1'b0} + {2'd0, b1_reg};
        s2 = {1'b0, b2_reg, 1'b0} + {2'd0, b2_reg};
        t1 = alo((s1 + g1) >> 2);
        t2 = alo((s2 + g2) >> 2);
        if (eb >= 2'd1)
        begin
            if (t1 < alo(ft >> 8)) t1 = alo(ft >> 8);
            if (t2 < alo(ft >> 7)) t2 = alo(ft >> 7);
        end
        if (eb >= 2'd2)
        begin
            if (t1 < alo(ft >> 7)) t1 = alo(ft >> 7);
            if (t2 < alo(ft >> 6)) t2 = alo(ft >> 6);
        end
        if (ratio_reg)
        begin
            priority if (r_reg < 7'd25)
            begin
                t1 = alo(t1 >> 2); t2 = alo(t2 >> 2);
            end
            else if (r_reg < 7'd35)
            begin
                t1 = alo(t1 >> 1); t2 = alo(t2 >> 1);
            end
            else if (r_reg < 7'd45)
            begin
                t1 = alo((t1 + (t1 << 1)) >> 2); t2 = alo((t2 + (t2 << 1)) >> 2);
            end
            else if (r_reg > 7'd70 && eb >= 2'd1)
            begin
                t1 = t1 + (t1 >> 2); t2 = t2 + (t2 >> 2);
            end
        end
        if (t1 > c1) t1 = c1;
        if (t2 > c2) t2 = c2;
    end

    logic [38:0] hot100;
    assign hot100 = {scan_hot, 7'd0} - {2'd0, scan_hot, 5'd0} + {5'd0, scan_hot, 2'd0};

    always_comb
    begin
        state_next = state_reg;
        now_next = now_reg;
        nat_next = nat_reg;
        lref_next = lref_reg;
        bl_next = bl_reg;
        bu_next = bu_reg;
        sts_next = sts_reg;
        shs_next = shs_reg;
        lt_next = lt_reg;
        lh_next = lh_reg;
        b1_next = b1_reg;
        b2_next = b2_reg;
        ft_next = ft_reg;
        six_next = six_reg;
        ratio_next = ratio_reg;
        r_next = r_reg;
        prot_next = prot_reg;
        aged_next = aged_reg;
        ov_next = ov_reg && out_stall;
        out_load = 1'b0;
        dreq = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    prot_next = 1'b0;
                    aged_next = 1'b0;
                    state_next = ST_OUT;
                    unique case (kind)
                        KIND_TICK: now_next = now_reg + 32'd1;
                        KIND_PROT:
                        begin
                            if (pr && bud >= {22'd0, pages})
                            begin
                                prot_next = 1'b1;
                                if (tier2) b2_next = b2_reg - {22'd0, pages};
                                else b1_next = b1_reg - {22'd0, pages};
                            end
                        end
                        KIND_LOOK:
                        begin
                            if (enable_reg && is_file)
                            begin
                                if (lt_reg < CMAX) lt_next = lt_reg + CB'(1);
                                if (referenced || workingset || active)
                                begin
                                    if (lh_reg < CMAX) lh_next = lh_reg + CB'(1);
                                    if (lt_next >= CB'(128) &&
                                        lh_next > (lt_next >> 1) + CB'(16))
                                    begin
                                        if (bl_reg == 2'd0) bl_next = 2'd1;
                                        if (!before32(now_reg, bu_reg))
                                            bu_next = now_reg + {22'd0, tps_reg};
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            if (enable_reg && !before32(now_reg, nat_reg))
                            begin
                                aged_next = 1'b1;
                                nat_next = now_reg + {22'd0, tps_reg};
                                lref_next = refault_count;
                                if (lvl0 != 2'd0)
                                begin
                                    sts_next = scan_total;
                                    shs_next = scan_hot;
                                    bl_next = lvl;
                                    bu_next = now_reg + ((lvl == 2'd3) ?
                                        {21'd0, tps_reg, 1'b0} : {22'd0, tps_reg});
                                end
                                else if (!before32(now_reg, bu_reg))
                                    bl_next = 2'd0;
                                lt_next = lt_reg >> 1;
                                lh_next = lh_reg >> 1;
                                ft_next = file_pages;
                                ratio_next = scan_total >= 32'd1024;
                                if (file_pages == 32'd0)
                                begin
                                    b1_next = '0;
                                    b2_next = '0;
                                end
                                else if (scan_total >= 32'd1024)
                                begin
                                    dreq.start = 1'b1;
                                    dreq.num = {1'b0, hot100};
                                    dreq.den = {8'd0, scan_total};
                                    state_next = ST_DIV_RATIO;
                                end
                                else
                                    state_next = ST_SIXTH;
                            end
                        end
                    endcase
                end
            end
            ST_DIV_RATIO:
            begin
                if (drsp.done)
                begin
                    r_next = (drsp.quo > 40'd100) ? 7'd100 : drsp.quo[6:0];
                    state_next = ST_SIXTH;
                end
            end
            ST_SIXTH:
            begin
                six_next = {2'd0, six_prod[62:33]};
                state_next = ST_BUDGET;
            end
            ST_BUDGET:
            begin
                b1_next = t1[31:0];
                b2_next = t2[31:0];
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    out_load = 1'b1;
                    ov_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_valid    = ov_reg;
    assign protect      = oprot_reg;
    assign aged         = oaged_reg;
    assign boost_now    = oboost_reg;
    assign tier1_budget = ob1_reg;
    assign tier2_budget = ob2_reg;

`include "reclaim_tier_protection_policy_unit_assert.svh"

    `RTP_ASSERT_IMP(a_no_take_busy, state_reg != ST_IDLE, in_stall, "input taken while busy")
    `RTP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(tier1_budget), "output beat lost")
    `RTP_ASSERT_IMP(a_div_idle, state_reg == ST_IDLE, !drsp.busy, "divider busy while idle")
    `RTP_ASSERT_IMP(a_flags, out_valid, !(protect && aged), "protect and aged together")
endmodule
